// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion helpers shared by the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

// File: rtl/bspf_pkg.sv
// ---------------------------------------------------------------------------
// bspf_pkg
// shared widths, register codes and divider lane types of the filter table
// ---------------------------------------------------------------------------
package bspf_pkg;

  localparam int unsigned IDX_W  = 12;  // entry_index
  localparam int unsigned SIZE_W = 13;  // table_size register
  localparam int unsigned D_W    = 13;  // clamped d = n-1
  localparam int unsigned SQ_W   = 2 * D_W;
  localparam int unsigned CB_W   = 3 * D_W;
  localparam int unsigned W_W    = 45;  // weights, divisors, remainders

  localparam int unsigned NLANE  = 4;
  localparam int unsigned LANE_X = 0;  // i / d
  localparam int unsigned LANE_A = 1;  // w1 / (w0 + w1)
  localparam int unsigned LANE_B = 2;  // w3 / (w2 + w3)
  localparam int unsigned LANE_G = 3;  // (w2 + w3) / 6d^3

  localparam logic               REG_TABLE_SIZE = 1'b0;
  localparam logic [SIZE_W-1:0]  TABLE_SIZE_RST = 13'd128;

  typedef struct packed {
    logic [W_W-1:0] rem;
    logic [W_W-1:0] den;
  } div_lane_t;

  typedef div_lane_t [NLANE-1:0] div_bus_t;

endpackage

// File: rtl/bspf_front.sv
// ---------------------------------------------------------------------------
// bspf_front
// clamps the index, forms the scaled spline weights over three stages
// ---------------------------------------------------------------------------
module bspf_front #(
  parameter int unsigned MAX_ENTRIES = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [2:0]                   en_i,
  input  logic                         v_i,
  input  logic [bspf_pkg::IDX_W-1:0]   idx_i,
  input  logic [bspf_pkg::SIZE_W-1:0]  table_size_i,
  output logic [2:0]                   v_o,
  output bspf_pkg::div_bus_t           bus_o
);

  localparam int unsigned DW = bspf_pkg::D_W;
  localparam int unsigned SW = bspf_pkg::SQ_W;
  localparam int unsigned CW = bspf_pkg::CB_W;
  localparam int unsigned WW = bspf_pkg::W_W;

  logic [2:0] v_q;

  logic [bspf_pkg::SIZE_W-1:0] n_c;
  logic [DW-1:0] d_c, i_c;

  logic [DW-1:0] i1_q, d1_q, e1_q;
  logic [SW-1:0] i2_q, d2_q, e2_q, id_q;

  logic [DW-1:0] i2s_q, d2s_q;
  logic [CW-1:0] i3_q, d3_q, e3_q, i2d_q, id2_q;

  logic [WW-1:0] w0, w1, w2, w3, i3w, d3w, i2dw, id2w;
  bspf_pkg::div_bus_t bus_d, bus_q;

  // clamp size and index
  always_comb begin
    n_c = table_size_i;
    if (n_c < bspf_pkg::SIZE_W'(2)) begin
      n_c = bspf_pkg::SIZE_W'(2);
    end
    if (17'(n_c) > 17'(MAX_ENTRIES)) begin
      n_c = bspf_pkg::SIZE_W'(MAX_ENTRIES);
    end
    d_c = DW'(n_c - bspf_pkg::SIZE_W'(1));
    i_c = (DW'(idx_i) > d_c) ? d_c : DW'(idx_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en_i[0]) v_q[0] <= v_i;
      if (en_i[1]) v_q[1] <= v_q[0];
      if (en_i[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      i1_q <= i_c;
      d1_q <= d_c;
      e1_q <= d_c - i_c;
      i2_q <= SW'(i_c) * SW'(i_c);
      d2_q <= SW'(d_c) * SW'(d_c);
      e2_q <= SW'(d_c - i_c) * SW'(d_c - i_c);
      id_q <= SW'(i_c) * SW'(d_c);
    end
    if (en_i[1]) begin
      i2s_q <= i1_q;
      d2s_q <= d1_q;
      i3_q  <= CW'(i2_q) * CW'(i1_q);
      d3_q  <= CW'(d2_q) * CW'(d1_q);
      e3_q  <= CW'(e2_q) * CW'(e1_q);
      i2d_q <= CW'(i2_q) * CW'(d1_q);
      id2_q <= CW'(id_q) * CW'(d1_q);
    end
    if (en_i[2]) begin
      bus_q <= bus_d;
    end
  end

  always_comb begin
    i3w  = WW'(i3_q);
    d3w  = WW'(d3_q);
    i2dw = WW'(i2d_q);
    id2w = WW'(id2_q);
    w0 = WW'(e3_q);
    w1 = (i3w * WW'(3)) + (d3w << 2) - (i2dw * WW'(6));
    w2 = (i2dw * WW'(3)) + (id2w * WW'(3)) + d3w - (i3w * WW'(3));
    w3 = i3w;
    bus_d[bspf_pkg::LANE_X].rem = WW'(i2s_q);
    bus_d[bspf_pkg::LANE_X].den = WW'(d2s_q);
    bus_d[bspf_pkg::LANE_A].rem = w1;
    bus_d[bspf_pkg::LANE_A].den = w0 + w1;
    bus_d[bspf_pkg::LANE_B].rem = w3;
    bus_d[bspf_pkg::LANE_B].den = w2 + w3;
    bus_d[bspf_pkg::LANE_G].rem = w2 + w3;
    bus_d[bspf_pkg::LANE_G].den = d3w * WW'(6);
  end

  assign v_o   = v_q;
  assign bus_o = bus_q;

endmodule

// File: rtl/bspf_div_cell.sv
// ---------------------------------------------------------------------------
// bspf_div_cell
// one restoring-division step for all four lanes, registered
// ---------------------------------------------------------------------------
module bspf_div_cell #(
  parameter int unsigned QW = 18
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    v_i,
  input  bspf_pkg::div_bus_t                      bus_i,
  input  logic [bspf_pkg::NLANE-1:0][QW-1:0]      q_i,
  output logic                                    v_o,
  output bspf_pkg::div_bus_t                      bus_o,
  output logic [bspf_pkg::NLANE-1:0][QW-1:0]      q_o
);

  logic                                v_q;
  bspf_pkg::div_bus_t                  bus_d, bus_q;
  logic [bspf_pkg::NLANE-1:0][QW-1:0]  q_d, q_q;
  logic [bspf_pkg::NLANE-1:0]          ge;

  always_comb begin
    for (int l = 0; l < bspf_pkg::NLANE; l++) begin
      ge[l] = bus_i[l].rem >= bus_i[l].den;
      bus_d[l].den = bus_i[l].den;
      // next cell sees the remainder already doubled
      bus_d[l].rem = (ge[l] ? (bus_i[l].rem - bus_i[l].den) : bus_i[l].rem) << 1;
      q_d[l] = {q_i[l][QW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bus_q <= bus_d;
      q_q   <= q_d;
    end
  end

  assign v_o   = v_q;
  assign bus_o = bus_q;
  assign q_o   = q_q;

endmodule

// File: rtl/cubic_bspline_filter_lut.sv
// ---------------------------------------------------------------------------
// cubic_bspline_filter_lut
// cubic b-spline fast-filter table entry generator
// ---------------------------------------------------------------------------
// usage:
//   input channel: entry_index_i with in_valid_i / in_ready_o, one beat per
//   table position. output channel: left_offset_o, right_offset_o and
//   right_weight_o with out_valid_o / out_ready_i, one beat per input beat,
//   in order. table_size is written over the apb port at address 0 while idle.
//   the pipeline runs through three stages of clamp and multiply, one
//   division cell per quotient bit (FRAC_BITS + 2 cells, four lanes each),
//   then the rounding and output register.
//   throughput is one beat per cycle; every stage holds its own valid bit so
//   bubbles collapse. when the receiver stalls the output register holds
//   and stages fill behind it; in_ready_o falls only once every stage is
//   full. reset empties the pipeline and sets table_size to 128.
// ---------------------------------------------------------------------------
module cubic_bspline_filter_lut #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned MAX_ENTRIES = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bspf_pkg::IDX_W-1:0]  entry_index_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [FRAC_BITS:0]          left_offset_o,
  output logic [FRAC_BITS:0]          right_offset_o,
  output logic [FRAC_BITS:0]          right_weight_o
);

  localparam int unsigned NCELL = FRAC_BITS + 2;
  localparam int unsigned QW    = FRAC_BITS + 2;
  localparam int unsigned NST   = 3 + NCELL + 1;
  localparam int unsigned OW    = FRAC_BITS + 1;
  localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;

  logic [bspf_pkg::SIZE_W-1:0] table_size_q;

  logic [NST-1:0] vld, en;

  bspf_pkg::div_bus_t                  bus   [NCELL+1];
  logic [bspf_pkg::NLANE-1:0][QW-1:0]  quo   [NCELL+1];
  logic [NCELL:0]                      cvld;

  logic [QW-1:0] qx, qa, qb, qg;
  logic [QW-1:0] s0, s1;
  logic [OW-1:0] h0_d, h1_d, g1_d;
  logic          out_valid_q;
  logic [OW-1:0] h0_q, h1_q, g1_q;

  // apb register
  assign pready = 1'b1;
  assign prdata = 32'(table_size_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= bspf_pkg::TABLE_SIZE_RST;
    end else if (psel && penable && pwrite && (paddr[2] == bspf_pkg::REG_TABLE_SIZE)) begin
      table_size_q <= pwdata[bspf_pkg::SIZE_W-1:0];
    end
  end

  // per-stage advance: a stage loads when empty or when its successor moves
  always_comb begin
    en[NST-1] = !vld[NST-1] || out_ready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  bspf_front #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en[2:0]),
    .v_i          (in_valid_i),
    .idx_i        (entry_index_i),
    .table_size_i (table_size_q),
    .v_o          (vld[2:0]),
    .bus_o        (bus[0])
  );

  assign cvld[0] = vld[2];
  assign quo[0]  = '0;

  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    bspf_div_cell #(
      .QW (QW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en[3+c]),
      .v_i    (cvld[c]),
      .bus_i  (bus[c]),
      .q_i    (quo[c]),
      .v_o    (cvld[c+1]),
      .bus_o  (bus[c+1]),
      .q_o    (quo[c+1])
    );
    assign vld[3+c] = cvld[c+1];
  end

  // round half up, combine, saturate
  always_comb begin
    qx = (quo[NCELL][bspf_pkg::LANE_X] + QW'(1)) >> 1;
    qa = (quo[NCELL][bspf_pkg::LANE_A] + QW'(1)) >> 1;
    qb = (quo[NCELL][bspf_pkg::LANE_B] + QW'(1)) >> 1;
    qg = (quo[NCELL][bspf_pkg::LANE_G] + QW'(1)) >> 1;
    s0 = ONE + qx - qa;
    s1 = ONE - qx + qb;
    h0_d = s0[QW-1] ? {OW{1'b1}} : s0[OW-1:0];
    h1_d = s1[QW-1] ? {OW{1'b1}} : s1[OW-1:0];
    g1_d = qg[QW-1] ? {OW{1'b1}} : qg[OW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en[NST-1]) begin
      out_valid_q <= cvld[NCELL];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NST-1] && cvld[NCELL]) begin
      h0_q <= h0_d;
      h1_q <= h1_d;
      g1_q <= g1_d;
    end
  end

  assign vld[NST-1]     = out_valid_q;
  assign out_valid_o    = out_valid_q;
  assign left_offset_o  = h0_q;
  assign right_offset_o = h1_q;
  assign right_weight_o = g1_q;

`include "assert_macros.svh"

  `ASSERT_CLK(a_block_only_full, clk_i, rst_ni, !in_ready_o |-> (&vld))
  `ASSERT_NEVER(a_quot_range, clk_i, rst_ni, cvld[NCELL] && ((qx > ONE) || (qa > ONE)))
  `ASSERT_CLK(a_drain, clk_i, rst_ni, (cvld[NCELL] && !out_valid_q) |=> out_valid_q)

endmodule

// File: sim/cubic_bspline_filter_lut_tb.sv
// ---------------------------------------------------------------------------
// cubic_bspline_filter_lut_tb
// checks filter-table entries against an exact rational predictor while
// table_size changes and both channels idle at random
// ---------------------------------------------------------------------------
module cubic_bspline_filter_lut_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FB = 16;
  localparam longint OUT_MAX = 131071;
  localparam int unsigned LATENCY = FB + 6;
  localparam longint LIMIT = 2000000;

  typedef struct packed {
    logic [FB:0] left_offset;
    logic [FB:0] right_offset;
    logic [FB:0] right_weight;
  } entry_t;

  // directed row: table size, index, whether the entry is typed in, the entry
  typedef struct {
    int unsigned tsize;
    int unsigned idx;
    bit          typed;
    entry_t      ent;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [bspf_pkg::IDX_W-1:0] entry_index_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [FB:0] left_offset_o, right_offset_o, right_weight_o;

  cubic_bspline_filter_lut i_dut (.*);

  always #4 clk_i = ~clk_i;

  entry_t      pending_q[$];
  int unsigned table_size_q = bspf_pkg::TABLE_SIZE_RST;
  int unsigned n_fail, n_beats, n_sent;
  int unsigned in_idle_pct, out_stall_pct;
  longint      cycle_cnt = 0;

  function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
    longint unsigned q, r;
    q = 0;
    r = num;
    if (r >= den) begin
      r -= den;
      q = 1;
    end
    for (int k = 0; k <= FB; k++) begin
      r <<= 1;
      q <<= 1;
      if (r >= den) begin
        r -= den;
        q |= 1;
      end
    end
    return (q + 1) >> 1;
  endfunction

  function automatic logic [FB:0] clip_out(longint v);
    if (v < 0) return '0;
    if (v > OUT_MAX) return OUT_MAX[FB:0];
    return v[FB:0];
  endfunction

  function automatic entry_t filter_entry(int unsigned tsize, int unsigned idx);
    longint unsigned n, d, i, d3, i3, w0, w1, w2, w3, xq, aq, bq, gq;
    longint one;
    entry_t e;
    one = longint'(1) << FB;
    n = tsize & 13'h1fff;
    if (n < 2) n = 2;
    if (n > 4096) n = 4096;
    d = n - 1;
    i = idx & 12'hfff;
    if (i > d) i = d;
    i3 = i * i * i;
    d3 = d * d * d;
    w0 = (d - i) * (d - i) * (d - i);
    w1 = 3 * i3 + 4 * d3 - 6 * i * i * d;
    w2 = 3 * i * i * d + 3 * i * d * d + d3 - 3 * i3;
    w3 = i3;
    xq = round_div(i, d);
    aq = round_div(w1, w0 + w1);
    bq = round_div(w3, w2 + w3);
    gq = round_div(w2 + w3, 6 * d3);
    e.left_offset  = clip_out(one + longint'(xq) - longint'(aq));
    e.right_offset = clip_out(one - longint'(xq) + longint'(bq));
    e.right_weight = clip_out(longint'(gq));
    return e;
  endfunction

  task automatic write_table_size(int unsigned v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {bspf_pkg::REG_TABLE_SIZE, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    table_size_q = v & 13'h1fff;
  endtask

  // wait for the pipeline to drain before touching the register
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // valid drops only while the sender idles or drains
  task automatic send_entry(int unsigned idx, entry_t exp_ent);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    entry_index_i <= idx[bspf_pkg::IDX_W-1:0];
    pending_q.push_back(exp_ent);
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
  endtask

  task automatic send_index(int unsigned idx);
    send_entry(idx, filter_entry(table_size_q, idx));
  endtask

  // receiver: random stall, compare each beat with the oldest expectation
  always @(posedge clk_i) begin
    entry_t e;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        n_beats++;
        if (pending_q.size() == 0) begin
          $error("result beat with nothing expected");
          n_fail++;
        end else begin
          e = pending_q.pop_front();
          if (left_offset_o !== e.left_offset) begin
            $error("left_offset exp %0d got %0d", e.left_offset, left_offset_o);
            n_fail++;
          end
          if (right_offset_o !== e.right_offset) begin
            $error("right_offset exp %0d got %0d", e.right_offset, right_offset_o);
            n_fail++;
          end
          if (right_weight_o !== e.right_weight) begin
            $error("right_weight exp %0d got %0d", e.right_weight, right_weight_o);
            n_fail++;
          end
        end
      end
      out_ready_i <= !(out_stall_pct != 0 && $urandom_range(99) < out_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (cycle_cnt > LIMIT) begin
      $display("cubic_bspline_filter_lut_tb NOT OK");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    int unsigned sizes[8];
    int unsigned ts, idx;
    entry_t dummy;
    dummy = '0;
    // after reset at 128 entries: x = 0 and x = 1 are known by hand
    rows.push_back('{128, 0, 1, '{17'd13107, 17'd65536, 17'd10923}});
    rows.push_back('{128, 127, 1, '{17'd65536, 17'd13107, 17'd54613}});
    rows.push_back('{128, 4095, 1, '{17'd65536, 17'd13107, 17'd54613}});
    rows.push_back('{128, 63, 0, dummy});
    rows.push_back('{128, 64, 0, dummy});
    rows.push_back('{2, 0, 1, '{17'd13107, 17'd65536, 17'd10923}});
    rows.push_back('{2, 1, 1, '{17'd65536, 17'd13107, 17'd54613}});
    rows.push_back('{2, 4095, 0, dummy});
    rows.push_back('{0, 0, 0, dummy});
    rows.push_back('{1, 2730, 0, dummy});
    rows.push_back('{4096, 0, 0, dummy});
    rows.push_back('{4096, 4095, 0, dummy});
    rows.push_back('{4096, 2048, 0, dummy});
    rows.push_back('{4096, 1365, 0, dummy});
    rows.push_back('{8191, 4094, 0, dummy});
    rows.push_back('{8191, 1, 0, dummy});
    rows.push_back('{3, 1, 0, dummy});
    rows.push_back('{3, 2, 0, dummy});
    rows.push_back('{5000, 3000, 0, dummy});
    rows.push_back('{100, 50, 0, dummy});
    in_idle_pct = 0;
    out_stall_pct = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[k]) begin
      if (rows[k].tsize != table_size_q) begin
        drain();
        write_table_size(rows[k].tsize);
      end
      if (rows[k].typed) send_entry(rows[k].idx, rows[k].ent);
      else send_index(rows[k].idx);
    end
    sizes = '{2, 4096, 8191, 128, 3, 1000, 0, 17};
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 87; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 87; end
        default: begin in_idle_pct = 8; out_stall_pct = 8; end
      endcase
      drain();
      ts = (ph % 2) ? $urandom_range(8191) : sizes[ph];
      write_table_size(ts);
      for (int k = 0; k < 125; k++) begin
        // mostly in-range positions, some past the end
        if ($urandom_range(9) < 8) idx = $urandom_range((ts < 2 ? 2 : ts) - 1);
        else idx = $urandom_range(4095);
        send_index(idx);
      end
    end
    drain();
    $display("sent %0d indexes over several table sizes and idle patterns, %0d beats",
             n_sent, n_beats);
    if (n_fail == 0) begin
      $display("cubic_bspline_filter_lut_tb OK");
    end else begin
      $display("cubic_bspline_filter_lut_tb NOT OK");
    end
    $finish;
  end

endmodule
